FILE: rtl/lca_binary_lifting_macros.svh
// ----------------------------------------------------------------------------
// lca_binary_lifting_macros.svh
// Assertion shorthands for the lowest common ancestor block, clocked on aclk
// and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LCA_BINARY_LIFTING_MACROS_SVH
`define LCA_BINARY_LIFTING_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define LCA_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define LCA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lcabl_pkg.sv
// ----------------------------------------------------------------------------
// lcabl_pkg
// Shared types and constants of the binary-lifting common ancestor block:
// command codes, register map and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lcabl_pkg;

    // Field widths fixed by the item format
    localparam int ID_W    = 10;
    localparam int CMD_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Command codes of an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Register map (word index above the byte offset)
    localparam logic [PADDR_W-3:0] REG_NODE_COUNT = '0;
    localparam logic [ID_W-1:0]    NODE_COUNT_RST = ID_W'(1);

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_LOAD,
        OP_FIX_RD,
        OP_FIX_WR,
        OP_JMP_RD1,
        OP_JMP_RD2,
        OP_JMP_WR,
        OP_DEP_INIT,
        OP_DEP_RD,
        OP_DEP_USE,
        OP_DEP_WR,
        OP_DEP_RDA,
        OP_DEP_RDB,
        OP_ORDER,
        OP_U_RD,
        OP_U_SET,
        OP_V_RD,
        OP_CLIMB,
        OP_RES_ERR,
        OP_RES_EQ,
        OP_RES_TOP
    } dp_op_t;

    // Level counter operations
    typedef enum logic [2:0] {
        LVL_HOLD,
        LVL_ZERO,
        LVL_TOP,
        LVL_INC,
        LVL_DEC
    } lvl_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    node_clr;
        logic    node_inc;
        lvl_op_t lvl;
    } dp_cmd_t;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
        logic node_last;
        logic lvl_zero;
        logic lvl_top;
        logic jump_last;
        logic raise_bit;
        logic uv_equal;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/lcabl_datapath.sv
// ----------------------------------------------------------------------------
// lcabl_datapath
// Ancestor and depth memories, loop counters, the lifting registers and the
// result register. Executes one operation per cycle as the controller says.
// ----------------------------------------------------------------------------
module lcabl_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lcabl_pkg::dp_cmd_t        cmd_i,
    output lcabl_pkg::dp_stat_t       stat_o,
    input  logic [lcabl_pkg::ID_W-1:0] node_count_i,
    input  logic [lcabl_pkg::ID_W-1:0] node_a_i,
    input  logic [lcabl_pkg::ID_W-1:0] node_b_i,
    input  logic                      m_ready_i,
    output logic                      m_valid_o,
    output logic [lcabl_pkg::ID_W-1:0] m_ancestor_o,
    output logic                      m_status_o
);
    import lcabl_pkg::*;

    localparam int NW        = $clog2(MAX_NODES);
    localparam int LW        = $clog2(LEVELS);
    localparam int AW        = LW + NW;
    localparam int ANC_DEPTH = LEVELS * (2 ** NW);

    // Memories
    logic [ID_W-1:0]   anc_mem [ANC_DEPTH];
    logic [LEVELS-1:0] dep_mem [MAX_NODES];

    logic              anc_rd, anc_we;
    logic [AW-1:0]     anc_raddr, anc_waddr;
    logic [ID_W-1:0]   anc_wdata;
    logic [ID_W-1:0]   anc_rdata_reg;
    logic              dep_rd, dep_we;
    logic [NW-1:0]     dep_raddr, dep_waddr;
    logic [LEVELS-1:0] dep_wdata;
    logic [LEVELS-1:0] dep_rdata_reg;

    // Counters and working registers
    logic [NW-1:0]     node_reg, node_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [ID_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [ID_W-1:0]   u_reg, u_next, v_reg, v_next, au_reg, au_next;
    logic [NW-1:0]     x_reg, x_next;
    logic [LEVELS-1:0] d_reg, d_next, da_reg, da_next, k_reg, k_next;

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_ancestor_reg, m_ancestor_next;
    logic              m_status_reg, m_status_next;

    logic              fix_keep;
    logic              out_free;

    function automatic logic id_ok(input logic [ID_W-1:0] id,
                                   input logic [ID_W-1:0] cnt);
        return (id != '0) && (id <= cnt) && (32'(id) < MAX_NODES);
    endfunction

    function automatic logic [NW-1:0] to_idx(input logic [ID_W-1:0] id);
        return NW'(id);
    endfunction

    function automatic logic [AW-1:0] anc_addr(input logic [LW-1:0] lvl,
                                               input logic [NW-1:0] idx);
        return {lvl, idx};
    endfunction

    assign out_free = !m_valid_reg || m_ready_i;

    // Root and out-of-range nodes, and nodes with an out-of-range parent, lose their parent link at build
    assign fix_keep = (node_reg > NW'(1)) && (32'(node_reg) <= 32'(node_count_i))
                      && id_ok(anc_rdata_reg, node_count_i);

    // Status toward the controller
    always_comb begin
        stat_o.a_ok      = id_ok(a_reg, node_count_i);
        stat_o.b_ok      = id_ok(b_reg, node_count_i);
        stat_o.node_last = (node_reg == NW'(MAX_NODES - 1));
        stat_o.lvl_zero  = (lvl_reg == '0);
        stat_o.lvl_top   = (lvl_reg == LW'(LEVELS - 1));
        stat_o.jump_last = (lvl_reg == LW'(LEVELS - 2));
        stat_o.raise_bit = k_reg[lvl_reg];
        stat_o.uv_equal  = (u_reg == v_reg);
        stat_o.out_free  = out_free;
    end

    // Decode the operation into memory ports and register updates
    always_comb begin
        anc_rd          = 1'b0;
        anc_we          = 1'b0;
        anc_raddr       = anc_addr(lvl_reg, node_reg);
        anc_waddr       = anc_addr(lvl_reg, node_reg);
        anc_wdata       = anc_rdata_reg;
        dep_rd          = 1'b0;
        dep_we          = 1'b0;
        dep_raddr       = to_idx(a_reg);
        dep_waddr       = node_reg;
        dep_wdata       = d_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        au_next         = au_reg;
        x_next          = x_reg;
        d_next          = d_reg;
        da_next         = da_reg;
        k_next          = k_reg;
        m_valid_next    = m_valid_reg && !m_ready_i;
        m_ancestor_next = m_ancestor_reg;
        m_status_next   = m_status_reg;

        unique case (cmd_i.op)
            OP_CAPTURE: begin
                a_next = node_a_i;
                b_next = node_b_i;
            end
            OP_LOAD: begin
                anc_we    = id_ok(a_reg, node_count_i);
                anc_waddr = anc_addr('0, to_idx(a_reg));
                anc_wdata = id_ok(b_reg, node_count_i) ? b_reg : '0;
            end
            OP_FIX_RD: begin
                anc_rd    = 1'b1;
                anc_raddr = anc_addr('0, node_reg);
            end
            OP_FIX_WR: begin
                anc_we    = 1'b1;
                anc_waddr = anc_addr('0, node_reg);
                anc_wdata = fix_keep ? anc_rdata_reg : '0;
            end
            OP_JMP_RD1: begin
                anc_rd    = 1'b1;
                anc_raddr = anc_addr(lvl_reg, node_reg);
            end
            OP_JMP_RD2: begin
                anc_rd    = 1'b1;
                anc_raddr = anc_addr(lvl_reg, to_idx(anc_rdata_reg));
            end
            OP_JMP_WR: begin
                anc_we    = 1'b1;
                anc_waddr = anc_addr(lvl_reg + LW'(1), node_reg);
            end
            OP_DEP_INIT: begin
                x_next = node_reg;
                d_next = '0;
            end
            OP_DEP_RD: begin
                anc_rd    = 1'b1;
                anc_raddr = anc_addr(lvl_reg, x_reg);
            end
            OP_DEP_USE: begin
                if (anc_rdata_reg != '0) begin
                    x_next = to_idx(anc_rdata_reg);
                    d_next = d_reg | (LEVELS'(1) << lvl_reg);
                end
            end
            OP_DEP_WR: begin
                dep_we = 1'b1;
            end
            OP_DEP_RDA: begin
                dep_rd    = 1'b1;
                dep_raddr = to_idx(a_reg);
            end
            OP_DEP_RDB: begin
                da_next   = dep_rdata_reg;
                dep_rd    = 1'b1;
                dep_raddr = to_idx(b_reg);
            end
            OP_ORDER: begin
                // Put the deeper node in u
                if (da_reg < dep_rdata_reg) begin
                    u_next = b_reg;
                    v_next = a_reg;
                    k_next = dep_rdata_reg - da_reg;
                end else begin
                    u_next = a_reg;
                    v_next = b_reg;
                    k_next = da_reg - dep_rdata_reg;
                end
            end
            OP_U_RD: begin
                anc_rd    = 1'b1;
                anc_raddr = anc_addr(lvl_reg, to_idx(u_reg));
            end
            OP_U_SET: begin
                u_next = anc_rdata_reg;
            end
            OP_V_RD: begin
                au_next   = anc_rdata_reg;
                anc_rd    = 1'b1;
                anc_raddr = anc_addr(lvl_reg, to_idx(v_reg));
            end
            OP_CLIMB: begin
                if (au_reg != anc_rdata_reg) begin
                    u_next = au_reg;
                    v_next = anc_rdata_reg;
                end
            end
            OP_RES_ERR: begin
                m_valid_next    = 1'b1;
                m_ancestor_next = '0;
                m_status_next   = 1'b1;
            end
            OP_RES_EQ: begin
                m_valid_next    = 1'b1;
                m_ancestor_next = u_reg;
                m_status_next   = 1'b0;
            end
            OP_RES_TOP: begin
                m_valid_next    = 1'b1;
                m_ancestor_next = anc_rdata_reg;
                m_status_next   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Loop counters
    always_comb begin
        node_next = node_reg;
        if (cmd_i.node_clr) begin
            node_next = '0;
        end else if (cmd_i.node_inc) begin
            node_next = node_reg + NW'(1);
        end

        unique case (cmd_i.lvl)
            LVL_ZERO: lvl_next = '0;
            LVL_TOP:  lvl_next = LW'(LEVELS - 1);
            LVL_INC:  lvl_next = lvl_reg + LW'(1);
            LVL_DEC:  lvl_next = lvl_reg - LW'(1);
            default:  lvl_next = lvl_reg;
        endcase
    end

    // Ancestor table: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (anc_we) begin
            anc_mem[anc_waddr] <= anc_wdata;
        end
        if (anc_rd) begin
            anc_rdata_reg <= anc_mem[anc_raddr];
        end
    end

    // Depth table
    always_ff @(posedge aclk) begin
        if (dep_we) begin
            dep_mem[dep_waddr] <= dep_wdata;
        end
        if (dep_rd) begin
            dep_rdata_reg <= dep_mem[dep_raddr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg    <= '0;
            lvl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            node_reg    <= node_next;
            lvl_reg     <= lvl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        au_reg         <= au_next;
        x_reg          <= x_next;
        d_reg          <= d_next;
        da_reg         <= da_next;
        k_reg          <= k_next;
        m_ancestor_reg <= m_ancestor_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid_o    = m_valid_reg;
    assign m_ancestor_o = m_ancestor_reg;
    assign m_status_o   = m_status_reg;

endmodule

FILE: rtl/lcabl_ctrl.sv
// ----------------------------------------------------------------------------
// lcabl_ctrl
// Sequencer for load, build and query commands. Tracks whether the ancestor
// tables are current and steers the datapath one operation per cycle.
// ----------------------------------------------------------------------------
module lcabl_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid_i,
    input  logic [lcabl_pkg::CMD_W-1:0] s_command_i,
    output logic                       s_ready_o,
    input  logic                       cfg_wr_i,
    input  lcabl_pkg::dp_stat_t        stat_i,
    output lcabl_pkg::dp_cmd_t         cmd_o
);
    import lcabl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_FIX_RD,
        S_FIX_WR,
        S_JMP_RD1,
        S_JMP_RD2,
        S_JMP_WR,
        S_DEP_INIT,
        S_DEP_RD,
        S_DEP_USE,
        S_DEP_WR,
        S_Q_CHECK,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_ORDER,
        S_RAISE_CHK,
        S_RAISE_RD,
        S_RAISE_SET,
        S_Q_EQ,
        S_CLB_RU,
        S_CLB_RV,
        S_CLB_CMP,
        S_TOP_RD,
        S_RES_ERR,
        S_RES_EQ,
        S_RES_TOP
    } state_t;

    state_t state_reg, state_next;
    logic   built_reg, built_next;

    assign s_ready_o = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        built_next     = built_reg;
        cmd_o.op       = OP_NOP;
        cmd_o.node_clr = 1'b0;
        cmd_o.node_inc = 1'b0;
        cmd_o.lvl      = LVL_HOLD;

        unique case (state_reg)
            S_IDLE: begin
                cmd_o.op       = OP_CAPTURE;
                cmd_o.node_clr = 1'b1;
                if (s_valid_i) begin
                    unique case (cmd_t'(s_command_i))
                        CMD_LOAD:  state_next = S_LOAD;
                        CMD_BUILD: state_next = S_FIX_RD;
                        CMD_QUERY: state_next = S_Q_CHECK;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                cmd_o.op = OP_LOAD;
                if (stat_i.a_ok) begin
                    built_next = 1'b0;
                end
                state_next = S_IDLE;
            end

            // Build, first pass: sanitize the parent links
            S_FIX_RD: begin
                cmd_o.op   = OP_FIX_RD;
                state_next = S_FIX_WR;
            end
            S_FIX_WR: begin
                cmd_o.op = OP_FIX_WR;
                if (stat_i.node_last) begin
                    cmd_o.node_clr = 1'b1;
                    cmd_o.lvl      = LVL_ZERO;
                    state_next     = S_JMP_RD1;
                end else begin
                    cmd_o.node_inc = 1'b1;
                    state_next     = S_FIX_RD;
                end
            end

            // Build, second pass: double the jump one level at a time
            S_JMP_RD1: begin
                cmd_o.op   = OP_JMP_RD1;
                state_next = S_JMP_RD2;
            end
            S_JMP_RD2: begin
                cmd_o.op   = OP_JMP_RD2;
                state_next = S_JMP_WR;
            end
            S_JMP_WR: begin
                cmd_o.op   = OP_JMP_WR;
                state_next = S_JMP_RD1;
                if (stat_i.node_last) begin
                    cmd_o.node_clr = 1'b1;
                    if (stat_i.jump_last) begin
                        state_next = S_DEP_INIT;
                    end else begin
                        cmd_o.lvl = LVL_INC;
                    end
                end else begin
                    cmd_o.node_inc = 1'b1;
                end
            end

            // Build, third pass: greedy ancestor count per node
            S_DEP_INIT: begin
                cmd_o.op   = OP_DEP_INIT;
                cmd_o.lvl  = LVL_TOP;
                state_next = S_DEP_RD;
            end
            S_DEP_RD: begin
                cmd_o.op   = OP_DEP_RD;
                state_next = S_DEP_USE;
            end
            S_DEP_USE: begin
                cmd_o.op = OP_DEP_USE;
                if (stat_i.lvl_zero) begin
                    state_next = S_DEP_WR;
                end else begin
                    cmd_o.lvl  = LVL_DEC;
                    state_next = S_DEP_RD;
                end
            end
            S_DEP_WR: begin
                cmd_o.op = OP_DEP_WR;
                if (stat_i.node_last) begin
                    cmd_o.node_clr = 1'b1;
                    built_next     = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    cmd_o.node_inc = 1'b1;
                    state_next     = S_DEP_INIT;
                end
            end

            // Query: check, then fetch both depths
            S_Q_CHECK: begin
                if (built_reg && stat_i.a_ok && stat_i.b_ok) begin
                    state_next = S_Q_RDA;
                end else begin
                    state_next = S_RES_ERR;
                end
            end
            S_Q_RDA: begin
                cmd_o.op   = OP_DEP_RDA;
                state_next = S_Q_RDB;
            end
            S_Q_RDB: begin
                cmd_o.op   = OP_DEP_RDB;
                state_next = S_Q_ORDER;
            end
            S_Q_ORDER: begin
                cmd_o.op   = OP_ORDER;
                cmd_o.lvl  = LVL_ZERO;
                state_next = S_RAISE_CHK;
            end

            // Raise the deeper node by the depth difference, bit by bit
            S_RAISE_CHK: begin
                if (stat_i.raise_bit) begin
                    state_next = S_RAISE_RD;
                end else if (stat_i.lvl_top) begin
                    state_next = S_Q_EQ;
                end else begin
                    cmd_o.lvl = LVL_INC;
                end
            end
            S_RAISE_RD: begin
                cmd_o.op   = OP_U_RD;
                state_next = S_RAISE_SET;
            end
            S_RAISE_SET: begin
                cmd_o.op = OP_U_SET;
                if (stat_i.lvl_top) begin
                    state_next = S_Q_EQ;
                end else begin
                    cmd_o.lvl  = LVL_INC;
                    state_next = S_RAISE_CHK;
                end
            end
            S_Q_EQ: begin
                if (stat_i.uv_equal) begin
                    state_next = S_RES_EQ;
                end else begin
                    cmd_o.lvl  = LVL_TOP;
                    state_next = S_CLB_RU;
                end
            end

            // Climb both nodes from the top level down
            S_CLB_RU: begin
                cmd_o.op   = OP_U_RD;
                state_next = S_CLB_RV;
            end
            S_CLB_RV: begin
                cmd_o.op   = OP_V_RD;
                state_next = S_CLB_CMP;
            end
            S_CLB_CMP: begin
                cmd_o.op = OP_CLIMB;
                if (stat_i.lvl_zero) begin
                    state_next = S_TOP_RD;
                end else begin
                    cmd_o.lvl  = LVL_DEC;
                    state_next = S_CLB_RU;
                end
            end
            S_TOP_RD: begin
                cmd_o.op   = OP_U_RD;
                state_next = S_RES_TOP;
            end

            // Hand the result over once the output register is free
            S_RES_ERR: begin
                if (stat_i.out_free) begin
                    cmd_o.op   = OP_RES_ERR;
                    state_next = S_IDLE;
                end
            end
            S_RES_EQ: begin
                if (stat_i.out_free) begin
                    cmd_o.op   = OP_RES_EQ;
                    state_next = S_IDLE;
                end
            end
            S_RES_TOP: begin
                if (stat_i.out_free) begin
                    cmd_o.op   = OP_RES_TOP;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A register write invalidates the tables
        if (cfg_wr_i) begin
            built_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            built_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            built_reg <= built_next;
        end
    end

endmodule

FILE: rtl/lca_binary_lifting.sv
// One item at a time: input is ready only while idle; a held result adds stalls.
// Reset (aresetn low, synchronous): tables marked not built, node_count = 1.
// ----------------------------------------------------------------------------
// lca_binary_lifting
// Lowest common ancestor by binary lifting over a parent-link tree, with an
// APB register for the node count.
// ----------------------------------------------------------------------------
`include "lca_binary_lifting_macros.svh"

module lca_binary_lifting #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcabl_pkg::PADDR_W-1:0] paddr,
    input  logic [lcabl_pkg::PDATA_W-1:0] pwdata,
    output logic [lcabl_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    // Command channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lcabl_pkg::CMD_W-1:0]   s_command,
    input  logic [lcabl_pkg::ID_W-1:0]    s_node_a,
    input  logic [lcabl_pkg::ID_W-1:0]    s_node_b,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lcabl_pkg::ID_W-1:0]    m_ancestor,
    output logic                          m_status
);
    import lcabl_pkg::*;

    logic            cfg_wr;
    logic [ID_W-1:0] node_count_reg, node_count_next;
    dp_cmd_t         dp_cmd;
    dp_stat_t        dp_stat;
    logic            cmd_xfer;
    logic            res_in_range;

    // Register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_NODE_COUNT);

    always_comb begin
        node_count_next = node_count_reg;
        if (cfg_wr) begin
            node_count_next = pwdata[ID_W-1:0];
        end
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_NODE_COUNT) begin
            prdata = PDATA_W'(node_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
        end else begin
            node_count_reg <= node_count_next;
        end
    end

    lcabl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid_i   (s_valid),
        .s_command_i (s_command),
        .s_ready_o   (s_ready),
        .cfg_wr_i    (cfg_wr),
        .stat_i      (dp_stat),
        .cmd_o       (dp_cmd)
    );

    lcabl_datapath #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_i        (dp_cmd),
        .stat_o       (dp_stat),
        .node_count_i (node_count_reg),
        .node_a_i     (s_node_a),
        .node_b_i     (s_node_b),
        .m_ready_i    (m_ready),
        .m_valid_o    (m_valid),
        .m_ancestor_o (m_ancestor),
        .m_status_o   (m_status)
    );

    // Terms for the checks below
    assign cmd_xfer     = s_valid && s_ready && (s_command != CMD_NONE);
    assign res_in_range = (m_ancestor <= node_count_reg);

    // An error result never names a node
    `LCA_CHECK_NOW(a_err_no_node, m_valid && m_status, m_ancestor == '0, "error names a node")

    // A good result is 0 or a node within the configured count
    `LCA_CHECK_NOW(a_ok_in_range, m_valid && !m_status, res_in_range, "result node out of range")

    // A real command keeps the block busy in the cycle after its transfer
    `LCA_CHECK_NEXT(a_busy_after_cmd, cmd_xfer, !s_ready, "ready after command transfer")

endmodule

FILE: dv/tb_lca_binary_lifting.sv
// ----------------------------------------------------------------------------
// tb_lca_binary_lifting
// Self-checking bench for the binary-lifting common ancestor block. It loads
// parent links, builds the tables and runs queries over directed trees, deep
// chains, random forests and noisy command streams. A built-in tree predictor
// computes each expected answer, and a monitor compares every result transfer
// in order. Both channels idle at random, and the node count register is
// written and read back between phases.
// ----------------------------------------------------------------------------
module tb_lca_binary_lifting;
    timeunit 1ns;
    timeprecision 1ps;

    import lcabl_pkg::*;

    localparam int NODES        = 1024;
    localparam int LVLS         = 10;
    localparam int BUILD_CYCLES = NODES * (5 * LVLS + 1);
    localparam int IDLE_PCT     = 27;

    typedef enum {SHAPE_BUSHY, SHAPE_DEEP} shape_t;

    typedef struct packed {
        logic [ID_W-1:0] ancestor;
        logic            status;
    } lca_result_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command = '0;
    logic [ID_W-1:0]     s_node_a  = '0;
    logic [ID_W-1:0]     s_node_b  = '0;
    logic                m_valid;
    logic                m_ready   = 1'b1;
    logic [ID_W-1:0]     m_ancestor;
    logic                m_status;

    // Tree predictor state
    logic [ID_W-1:0]     jump_tab [NODES][LVLS];
    logic [ID_W-1:0]     depth_tab [NODES];
    bit                  link_loaded [NODES];
    bit                  tables_ready;
    logic [ID_W-1:0]     node_limit;
    lca_result_t         lca_expect_q[$];
    lca_result_t         due_result;

    int                  errors;
    bit                  calm;
    bit                  build_busy;

    lca_binary_lifting #(
        .MAX_NODES (NODES),
        .LEVELS    (LVLS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_node_a   (s_node_a),
        .s_node_b   (s_node_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_ancestor (m_ancestor),
        .m_status   (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit in_tree(logic [ID_W-1:0] id);
        return id >= 1 && id <= node_limit;
    endfunction

    // Fix level 0, fill the lifting levels, then count depths greedily
    function automatic void rebuild_jumps();
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] x;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] d;
        for (int i = 0; i < NODES; i++) begin
            p = jump_tab[i][0];
            if (i <= 1 || !in_tree(ID_W'(i)) || !in_tree(p))
                p = '0;
            jump_tab[i][0] = p;
        end
        for (int j = 1; j < LVLS; j++)
            for (int i = 0; i < NODES; i++)
                jump_tab[i][j] = jump_tab[jump_tab[i][j-1]][j-1];
        for (int i = 0; i < NODES; i++) begin
            x = ID_W'(i);
            d = '0;
            for (int j = LVLS - 1; j >= 0; j--) begin
                a = jump_tab[x][j];
                if (a != '0) begin
                    x = a;
                    d = d + ID_W'(1 << j);
                end
            end
            depth_tab[i] = d;
        end
        tables_ready = 1'b1;
    endfunction

    function automatic logic [ID_W-1:0] common_ancestor(logic [ID_W-1:0] u,
                                                         logic [ID_W-1:0] v);
        logic [ID_W-1:0] t;
        logic [ID_W-1:0] k;
        logic [ID_W-1:0] au;
        logic [ID_W-1:0] av;
        if (depth_tab[u] < depth_tab[v]) begin
            t = u;
            u = v;
            v = t;
        end
        k = depth_tab[u] - depth_tab[v];
        for (int i = 0; i < LVLS; i++)
            if (k[i])
                u = jump_tab[u][i];
        if (u == v)
            return u;
        for (int i = LVLS - 1; i >= 0; i--) begin
            au = jump_tab[u][i];
            av = jump_tab[v][i];
            if (au != av) begin
                u = au;
                v = av;
            end
        end
        return jump_tab[u][0];
    endfunction

    // Apply one accepted command and queue the answer it owes
    function automatic void advance_tree(cmd_t cmd, logic [ID_W-1:0] a,
                                         logic [ID_W-1:0] b);
        lca_result_t res;
        case (cmd)
            CMD_LOAD: begin
                if (in_tree(a)) begin
                    jump_tab[a][0] = in_tree(b) ? b : '0;
                    link_loaded[a] = 1'b1;
                    tables_ready   = 1'b0;
                end
            end
            CMD_BUILD: begin
                rebuild_jumps();
            end
            CMD_QUERY: begin
                if (!tables_ready || !in_tree(a) || !in_tree(b)) begin
                    res.ancestor = '0;
                    res.status   = 1'b1;
                end else begin
                    res.ancestor = common_ancestor(a, b);
                    res.status   = 1'b0;
                end
                lca_expect_q = {lca_expect_q, res};
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lca_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0d/%0d",
                         $time, m_ancestor, m_status);
            end else begin
                due_result = lca_expect_q.pop_front();
                if (m_ancestor !== due_result.ancestor) begin
                    errors++;
                    $display("%0t: ancestor mismatch: expected %0d, actual %0d",
                             $time, due_result.ancestor, m_ancestor);
                end
                if (m_status !== due_result.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, due_result.status, m_status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers; every task starts and returns just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(cmd_t cmd, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_node_a  <= a;
        s_node_b  <= b;
        do @(posedge aclk); while (!s_ready);
        advance_tree(cmd, a, b);
        build_busy = (cmd == CMD_BUILD);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every answer, then let the block go idle
    task automatic settle();
        s_valid <= 1'b0;
        while (lca_expect_q.size() != 0)
            @(negedge aclk);
        repeat (build_busy ? BUILD_CYCLES + 64 : 16)
            @(negedge aclk);
    endtask

    // Write the node count, then read it back
    task automatic write_node_count(logic [ID_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NODE_COUNT, 2'b00};
        pwdata  <= PDATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        node_limit   = v;
        tables_ready = 1'b0;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== PDATA_W'(v)) begin
            errors++;
            $display("%0t: node_count readback mismatch: expected %0d, actual %0d",
                     $time, v, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load a fresh parent link for every node 2..node_limit
    task automatic load_forest(shape_t shape);
        logic [ID_W-1:0] p;
        int              r;
        for (int i = 2; i <= int'(node_limit); i++) begin
            r = $urandom_range(99);
            if (shape == SHAPE_DEEP)
                p = (r < 85) ? ID_W'(i - 1) : ID_W'($urandom_range(1, i - 1));
            else if (r < 80)
                p = ID_W'($urandom_range(1, i - 1));
            else if (r < 88)
                p = '0;
            else if (r < 94)
                p = ID_W'($urandom_range(1, int'(node_limit)));
            else
                p = ID_W'($urandom);
            send_item(CMD_LOAD, ID_W'(i), p);
        end
        // Root link is dropped at build time
        if ($urandom_range(1))
            send_item(CMD_LOAD, ID_W'(1), ID_W'($urandom));
    endtask

    // Make sure every live node has a link, then build
    task automatic rebuild_tree();
        for (int i = 2; i <= int'(node_limit); i++)
            if (!link_loaded[i])
                send_item(CMD_LOAD, ID_W'(i), ID_W'(1));
        send_item(CMD_BUILD, ID_W'($urandom), ID_W'($urandom));
    endtask

    task automatic query_burst(int n);
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] t;
        int              r;
        for (int q = 0; q < n; q++) begin
            r = $urandom_range(99);
            a = ID_W'($urandom_range(1, int'(node_limit)));
            b = ID_W'($urandom_range(1, int'(node_limit)));
            if (r >= 80 && r < 86) begin
                b = a;
            end else if (r >= 86 && r < 93) begin
                b = $urandom_range(1) ? '0 : node_limit + 1'b1;
                if ($urandom_range(1)) begin
                    t = a;
                    a = b;
                    b = t;
                end
            end else if (r >= 93) begin
                a = ID_W'($urandom);
                b = ID_W'($urandom);
            end
            // Hold off now and then until all answers are back
            if ($urandom_range(99) < 3)
                settle();
            send_item(CMD_QUERY, a, b);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_tree();
        send_item(CMD_QUERY, ID_W'(1), ID_W'(1));
        settle();
        write_node_count(ID_W'(8));
        send_item(CMD_LOAD, ID_W'(2), ID_W'(1));
        send_item(CMD_LOAD, ID_W'(3), ID_W'(1));
        send_item(CMD_LOAD, ID_W'(4), ID_W'(2));
        send_item(CMD_LOAD, ID_W'(5), ID_W'(2));
        send_item(CMD_LOAD, ID_W'(6), ID_W'(3));
        send_item(CMD_LOAD, ID_W'(7), ID_W'(4));
        send_item(CMD_LOAD, ID_W'(8), ID_W'(7));
        send_item(CMD_LOAD, ID_W'(1), ID_W'(3));
        send_item(CMD_LOAD, ID_W'(0), ID_W'(1));
        send_item(CMD_LOAD, ID_W'(1023), ID_W'(5));
        send_item(CMD_LOAD, ID_W'(5), ID_W'(1023));
        send_item(CMD_NONE, ID_W'(1023), ID_W'(1023));
        send_item(CMD_BUILD, ID_W'(0), ID_W'(0));
        send_item(CMD_QUERY, ID_W'(8), ID_W'(6));
        send_item(CMD_QUERY, ID_W'(7), ID_W'(4));
        send_item(CMD_QUERY, ID_W'(8), ID_W'(5));
        send_item(CMD_QUERY, ID_W'(8), ID_W'(8));
        settle();
        send_item(CMD_QUERY, ID_W'(0), ID_W'(3));
        send_item(CMD_QUERY, ID_W'(3), ID_W'(9));
        send_item(CMD_QUERY, ID_W'(1023), ID_W'(1023));
        send_item(CMD_QUERY, ID_W'(4), ID_W'(8));
        send_item(CMD_LOAD, ID_W'(6), ID_W'(2));
        send_item(CMD_QUERY, ID_W'(6), ID_W'(3));
        settle();
    endtask

    task automatic test_deep_chain();
        write_node_count(ID_W'(200));
        calm = 1'b1;
        load_forest(SHAPE_DEEP);
        calm = 1'b0;
        rebuild_tree();
        send_item(CMD_QUERY, ID_W'(200), ID_W'(1));
        send_item(CMD_QUERY, ID_W'(1), ID_W'(200));
        send_item(CMD_QUERY, ID_W'(200), ID_W'(200));
        send_item(CMD_QUERY, ID_W'(199), ID_W'(200));
        send_item(CMD_QUERY, ID_W'(200), ID_W'(2));
        query_burst(20);
        settle();
    endtask

    // Shrink the tree over the links already held and rebuild
    task automatic test_reused_links();
        write_node_count(ID_W'($urandom_range(60, 180)));
        send_item(CMD_QUERY, ID_W'(1), ID_W'(2));
        rebuild_tree();
        query_burst(15);
        settle();
    endtask

    task automatic test_random_forests();
        logic [ID_W-1:0] sizes [4];
        sizes[0] = ID_W'(2);
        sizes[1] = ID_W'($urandom_range(3, 8));
        sizes[2] = ID_W'($urandom_range(9, 20));
        sizes[3] = ID_W'($urandom_range(21, 40));
        foreach (sizes[s]) begin
            write_node_count(sizes[s]);
            load_forest(SHAPE_BUSHY);
            rebuild_tree();
            query_burst(10);
            settle();
        end
    endtask

    // Interleave stray loads and unused commands with queries
    task automatic test_noisy_commands();
        int r;
        write_node_count(ID_W'($urandom_range(12, 24)));
        load_forest(SHAPE_BUSHY);
        rebuild_tree();
        for (int n = 0; n < 30; n++) begin
            r = $urandom_range(99);
            if (r < 65)
                query_burst(1);
            else if (r < 80)
                send_item(CMD_LOAD, ID_W'($urandom), ID_W'($urandom));
            else if (r < 88)
                send_item(CMD_NONE, ID_W'($urandom), ID_W'($urandom));
            else
                send_item(CMD_QUERY, ID_W'($urandom), ID_W'($urandom));
        end
        rebuild_tree();
        query_burst(10);
        settle();
    endtask

    task automatic test_single_node();
        write_node_count(ID_W'(1));
        send_item(CMD_QUERY, ID_W'(1), ID_W'(1));
        rebuild_tree();
        send_item(CMD_QUERY, ID_W'(1), ID_W'(1));
        send_item(CMD_QUERY, ID_W'(1), ID_W'(2));
        send_item(CMD_QUERY, ID_W'(0), ID_W'(1));
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NODES; i++) begin
            for (int j = 0; j < LVLS; j++)
                jump_tab[i][j] = '0;
            depth_tab[i]   = '0;
            link_loaded[i] = 1'b0;
        end
        tables_ready = 1'b0;
        node_limit   = NODE_COUNT_RST;
        errors       = 0;
        calm         = 1'b0;
        build_busy   = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_tree();
        test_deep_chain();
        test_reused_links();
        test_random_forests();
        test_noisy_commands();
        test_single_node();
        settle();

        if (errors == 0)
            $display("tb_lca_binary_lifting passed");
        else
            $display("tb_lca_binary_lifting failed");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #30_000_000;
        $display("tb_lca_binary_lifting failed");
        $finish;
    end

endmodule
